FILE: src/lca_binary_lifting_macros.svh
// assertion macros used by the lca binary lifting checker
`ifndef LCA_BINARY_LIFTING_MACROS_SVH
`define LCA_BINARY_LIFTING_MACROS_SVH

// same-cycle implication, off during reset
`define LCABL_AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcabl check failed");

// next-cycle implication, off during reset
`define LCABL_AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcabl check failed");

// what must hold in the cycle after a reset cycle
`define LCABL_AST_RST(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("lcabl reset check failed");

`endif

FILE: src/lcabl_pkg.sv
// types, sizes and helper functions of the lca binary lifting block
`timescale 1ns / 1ps
`default_nettype none

package lcabl_pkg;

    localparam int MAX_NODES = 1024;
    localparam int LEVELS    = 10;
    localparam int NODE_FW   = 10;
    localparam int REQ_FW    = 2;
    localparam int NW        = $clog2(MAX_NODES);
    localparam int SLOTS     = 2 * MAX_NODES;
    localparam int EW        = $clog2(SLOTS);
    localparam int SPW       = NW + 1;
    localparam int LW        = $clog2(LEVELS + 1);
    localparam int AW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int KW        = $clog2(NW + 1);
    localparam int QD        = 2;
    localparam int QAW       = $clog2(QD);

    typedef logic [NW-1:0] t_node;
    typedef logic [EW-1:0] t_slot;

    typedef enum logic [REQ_FW-1:0] {
        REQ_ADD   = 2'd0,
        REQ_BUILD = 2'd1,
        REQ_QUERY = 2'd2
    } t_req;

    typedef struct packed {
        t_req  req;
        t_node a;
        t_node b;
    } t_cmd;

    typedef struct packed {
        logic init_done;
        logic busy;
    } t_back_stat;

    typedef struct packed {
        t_node                  depth;
        logic [LEVELS-1:0][NW-1:0] anc;
    } t_row;

    typedef struct packed {
        t_node target;
        t_slot next;
    } t_edge;

    typedef struct packed {
        t_node node;
        t_slot iter;
    } t_stk;

    // floor(log2 v) + 1, zero for zero
    function automatic logic [KW-1:0] prio_enc(input t_node v);
        logic [KW-1:0] n;
        n = '0;
        for (int i = 0; i < NW; i++) begin
            if (v[i]) begin
                n = KW'(i + 1);
            end
        end
        return n;
    endfunction

    // ancestor at a level, zero past the top level
    function automatic t_node anc_sel(input t_row r, input logic [KW-1:0] lv);
        t_node v;
        v = '0;
        if (int'(lv) < LEVELS) begin
            v = r.anc[AW'(lv)];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: src/lcabl_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface lcabl_in_if;
    import lcabl_pkg::*;
    logic               valid;
    logic               ready;
    logic [REQ_FW-1:0]  req_type;
    logic [NODE_FW-1:0] node_a;
    logic [NODE_FW-1:0] node_b;
    modport source (output valid, req_type, node_a, node_b, input ready);
    modport sink (input valid, req_type, node_a, node_b, output ready);
endinterface

interface lcabl_out_if;
    import lcabl_pkg::*;
    logic               valid;
    logic               ready;
    logic [NODE_FW-1:0] ancestor;
    logic               query_ok;
    modport source (output valid, ancestor, query_ok, input ready);
    modport sink (input valid, ancestor, query_ok, output ready);
endinterface

`default_nettype wire

FILE: src/lcabl_front.sv
// request intake: accepts words, drops unused codes, hands commands to the queue
`timescale 1ns / 1ps
`default_nettype none

module lcabl_front (
    input  wire logic                        i_valid,
    input  wire logic [lcabl_pkg::REQ_FW-1:0]  i_req_type,
    input  wire logic [lcabl_pkg::NODE_FW-1:0] i_node_a,
    input  wire logic [lcabl_pkg::NODE_FW-1:0] i_node_b,
    output logic                             o_ready,
    input  wire logic                        i_q_full,
    input  wire lcabl_pkg::t_back_stat       i_stat,
    output logic                             o_push,
    output lcabl_pkg::t_cmd                  o_cmd
);
    import lcabl_pkg::*;

    logic code_ok;

    // nothing is taken while the list heads are still being cleared
    assign o_ready  = i_stat.init_done && !i_q_full;
    assign code_ok  = (i_req_type == REQ_ADD) || (i_req_type == REQ_BUILD)
                   || (i_req_type == REQ_QUERY);
    assign o_push   = i_valid && o_ready && code_ok;
    assign o_cmd.req = t_req'(i_req_type);
    assign o_cmd.a   = NW'(i_node_a);
    assign o_cmd.b   = NW'(i_node_b);

endmodule

`default_nettype wire

FILE: src/lcabl_queue.sv
// short command queue between intake and engine
`timescale 1ns / 1ps
`default_nettype none

module lcabl_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire lcabl_pkg::t_cmd i_cmd,
    output logic                 o_full,
    output logic                 o_valid,
    output lcabl_pkg::t_cmd      o_cmd,
    input  wire logic            i_pop
);
    import lcabl_pkg::*;

    t_cmd           r_mem [QD];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QAW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QD));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == QAW'(QD - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == QAW'(QD - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: src/lcabl_back.sv
// engine: edge lists, depth-first table build and ancestor queries
`timescale 1ns / 1ps
`default_nettype none

module lcabl_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cmd_valid,
    input  wire lcabl_pkg::t_cmd              i_cmd,
    output logic                              o_cmd_pop,
    input  wire logic                         i_cfg_we,
    input  wire logic [lcabl_pkg::NODE_FW-1:0] i_cfg_wdata,
    output logic                              o_res_valid,
    input  wire logic                         i_res_ready,
    output logic [lcabl_pkg::NODE_FW-1:0]      o_res_anc,
    output logic                              o_res_ok,
    output lcabl_pkg::t_back_stat             o_stat
);
    import lcabl_pkg::*;

    typedef enum logic [23:0] {
        S_INIT   = 24'd1 << 0,
        S_IDLE   = 24'd1 << 1,
        S_ADD_RA = 24'd1 << 2,
        S_ADD_WA = 24'd1 << 3,
        S_ADD_RB = 24'd1 << 4,
        S_ADD_WB = 24'd1 << 5,
        S_B_CLR  = 24'd1 << 6,
        S_B_ROOT = 24'd1 << 7,
        S_V_RDP  = 24'd1 << 8,
        S_V_P    = 24'd1 << 9,
        S_V_CHK  = 24'd1 << 10,
        S_V_L    = 24'd1 << 11,
        S_V_PUSH = 24'd1 << 12,
        S_V_HEAD = 24'd1 << 13,
        S_W_TOP  = 24'd1 << 14,
        S_W_POP  = 24'd1 << 15,
        S_W_EDGE = 24'd1 << 16,
        S_W_SEEN = 24'd1 << 17,
        S_Q_RX   = 24'd1 << 18,
        S_Q_RY   = 24'd1 << 19,
        S_Q_LIFT = 24'd1 << 20,
        S_Q_LRD  = 24'd1 << 21,
        S_Q_K    = 24'd1 << 22,
        S_Q_OUT  = 24'd1 << 23
    } t_state;

    // memories
    t_slot head_mem [MAX_NODES];
    t_edge edge_mem [SLOTS];
    t_row  row_mem  [MAX_NODES];
    t_stk  stk_mem  [MAX_NODES];

    t_slot r_head_q;
    t_edge r_edge_q;
    t_row  r_row_q;
    t_stk  r_stk_q;

    logic  head_we, edge_we, row_we, stk_we;
    t_node head_raddr, head_waddr, row_raddr, row_waddr, stk_raddr, stk_waddr;
    t_slot head_wdata, edge_raddr, edge_waddr;
    t_edge edge_wdata;
    t_row  row_wdata;
    t_stk  stk_wdata;

    // control
    t_state          r_state, n_state;
    t_node           r_cnt, n_cnt;
    t_slot           r_ecount, n_ecount;
    logic            r_built, n_built;
    logic [SPW-1:0]  r_sp, n_sp;
    t_node           r_root, n_root;
    logic            r_out_valid, n_out_valid;

    // payload
    t_cmd            r_cmd, n_cmd;
    t_node           r_top_node, n_top_node;
    t_slot           r_top_iter, n_top_iter;
    t_node           r_t, n_t;
    t_node           r_vnode, n_vnode;
    t_node           r_vpar, n_vpar;
    t_row            r_vrow, n_vrow;
    logic [LW-1:0]   r_lvl, n_lvl;
    t_node           r_x, n_x;
    t_node           r_y, n_y;
    t_row            r_rowx, n_rowx;
    t_row            r_rowy, n_rowy;
    logic [KW-1:0]   r_k, n_k;
    logic            r_tail, n_tail;
    t_node           r_res, n_res;
    logic            r_res_ok, n_res_ok;
    t_node           r_out_anc, n_out_anc;
    logic            r_out_ok, n_out_ok;

    t_node           lift_nx, k_ax, k_ay;
    logic [KW-1:0]   lift_lv;

    assign o_cmd_pop      = (r_state == S_IDLE) && i_cmd_valid;
    assign o_res_valid    = r_out_valid;
    assign o_res_anc      = NODE_FW'(r_out_anc);
    assign o_res_ok       = r_out_ok;
    assign o_stat.init_done = (r_state != S_INIT);
    assign o_stat.busy      = (r_state != S_IDLE);

    assign lift_lv = prio_enc(r_rowx.depth - r_rowy.depth) - 1'b1;
    assign lift_nx = anc_sel(r_rowx, lift_lv);
    assign k_ax    = anc_sel(r_rowx, r_k);
    assign k_ay    = anc_sel(r_rowy, r_k);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ecount    = r_ecount;
        n_built     = r_built;
        n_sp        = r_sp;
        n_root      = i_cfg_we ? NW'(i_cfg_wdata) : r_root;
        n_out_valid = r_out_valid && !i_res_ready;
        n_cmd       = r_cmd;
        n_top_node  = r_top_node;
        n_top_iter  = r_top_iter;
        n_t         = r_t;
        n_vnode     = r_vnode;
        n_vpar      = r_vpar;
        n_vrow      = r_vrow;
        n_lvl       = r_lvl;
        n_x         = r_x;
        n_y         = r_y;
        n_rowx      = r_rowx;
        n_rowy      = r_rowy;
        n_k         = r_k;
        n_tail      = r_tail;
        n_res       = r_res;
        n_res_ok    = r_res_ok;
        n_out_anc   = r_out_anc;
        n_out_ok    = r_out_ok;
        head_we     = 1'b0;
        head_raddr  = r_cmd.a;
        head_waddr  = r_cnt;
        head_wdata  = '0;
        edge_we     = 1'b0;
        edge_raddr  = r_top_iter;
        edge_waddr  = r_ecount + 1'b1;
        edge_wdata  = '{target: r_cmd.b, next: r_head_q};
        row_we      = 1'b0;
        row_raddr   = r_vpar;
        row_waddr   = r_cnt;
        row_wdata   = '0;
        stk_we      = 1'b0;
        stk_raddr   = NW'(r_sp - SPW'(2));
        stk_waddr   = NW'(r_sp - SPW'(1));
        stk_wdata   = '{node: r_top_node, iter: r_top_iter};

        case (r_state)
            S_INIT: begin
                head_we = 1'b1;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == NW'(MAX_NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                row_raddr = i_cmd.a;
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    case (i_cmd.req)
                        REQ_ADD: begin
                            if (r_ecount <= EW'(SLOTS - 3)) begin
                                n_state = S_ADD_RA;
                            end
                        end
                        REQ_BUILD: begin
                            n_cnt   = '0;
                            n_state = S_B_CLR;
                        end
                        REQ_QUERY: begin
                            if (r_built) begin
                                n_x     = i_cmd.a;
                                n_y     = i_cmd.b;
                                n_tail  = 1'b0;
                                n_state = S_Q_RX;
                            end else begin
                                n_res    = '0;
                                n_res_ok = 1'b0;
                                n_state  = S_Q_OUT;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_RA: begin
                head_raddr = r_cmd.a;
                n_state    = S_ADD_WA;
            end
            S_ADD_WA: begin
                edge_we    = 1'b1;
                head_we    = 1'b1;
                head_waddr = r_cmd.a;
                head_wdata = r_ecount + 1'b1;
                n_ecount   = r_ecount + 1'b1;
                n_state    = S_ADD_RB;
            end
            S_ADD_RB: begin
                head_raddr = r_cmd.b;
                n_state    = S_ADD_WB;
            end
            S_ADD_WB: begin
                edge_we    = 1'b1;
                edge_wdata = '{target: r_cmd.a, next: r_head_q};
                head_we    = 1'b1;
                head_waddr = r_cmd.b;
                head_wdata = r_ecount + 1'b1;
                n_ecount   = r_ecount + 1'b1;
                n_state    = S_IDLE;
            end
            S_B_CLR: begin
                row_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == NW'(MAX_NODES - 1)) begin
                    n_state = S_B_ROOT;
                end
            end
            S_B_ROOT: begin
                n_built = 1'b1;
                n_sp    = '0;
                n_vnode = r_root;
                n_vpar  = '0;
                n_state = (r_root == '0) ? S_IDLE : S_V_RDP;
            end
            S_V_RDP: begin
                row_raddr = r_vpar;
                n_state   = S_V_P;
            end
            S_V_P: begin
                n_vrow        = '0;
                n_vrow.depth  = r_row_q.depth + 1'b1;
                n_vrow.anc[0] = r_vpar;
                n_lvl         = LW'(1);
                n_state       = S_V_CHK;
            end
            S_V_CHK: begin
                row_raddr = r_vrow.anc[AW'(r_lvl - 1'b1)];
                if ((int'(r_lvl) < LEVELS) && ((r_vrow.depth >> r_lvl) != '0)) begin
                    n_state = S_V_L;
                end else begin
                    row_we    = 1'b1;
                    row_waddr = r_vnode;
                    row_wdata = r_vrow;
                    n_state   = S_V_PUSH;
                end
            end
            S_V_L: begin
                n_vrow.anc[AW'(r_lvl)] = r_row_q.anc[AW'(r_lvl - 1'b1)];
                n_lvl   = r_lvl + 1'b1;
                n_state = S_V_CHK;
            end
            S_V_PUSH: begin
                // parent frame goes below the new top
                stk_we     = (r_sp != '0);
                head_raddr = r_vnode;
                n_state    = S_V_HEAD;
            end
            S_V_HEAD: begin
                n_top_node = r_vnode;
                n_top_iter = r_head_q;
                n_sp       = r_sp + 1'b1;
                n_state    = S_W_TOP;
            end
            S_W_TOP: begin
                if (r_top_iter == '0) begin
                    n_sp = r_sp - 1'b1;
                    n_state = (r_sp == SPW'(1)) ? S_IDLE : S_W_POP;
                end else begin
                    n_state = S_W_EDGE;
                end
            end
            S_W_POP: begin
                n_top_node = r_stk_q.node;
                n_top_iter = r_stk_q.iter;
                n_state    = S_W_TOP;
            end
            S_W_EDGE: begin
                n_top_iter = r_edge_q.next;
                n_t        = r_edge_q.target;
                row_raddr  = r_edge_q.target;
                if ((r_edge_q.target == '0) || (r_sp == SPW'(MAX_NODES))) begin
                    n_state = S_W_TOP;
                end else begin
                    n_state = S_W_SEEN;
                end
            end
            S_W_SEEN: begin
                // a nonzero depth marks a node already visited
                if (r_row_q.depth != '0) begin
                    n_state = S_W_TOP;
                end else begin
                    n_vnode = r_t;
                    n_vpar  = r_top_node;
                    n_state = S_V_RDP;
                end
            end
            S_Q_RX: begin
                n_rowx    = r_row_q;
                row_raddr = r_y;
                n_state   = S_Q_RY;
            end
            S_Q_RY: begin
                n_rowy = r_row_q;
                if (!r_tail) begin
                    if (r_rowx.depth < r_row_q.depth) begin
                        n_rowx = r_row_q;
                        n_rowy = r_rowx;
                        n_x    = r_y;
                        n_y    = r_x;
                    end
                    n_state = S_Q_LIFT;
                end else if (r_k == '0) begin
                    n_res    = anc_sel(r_rowx, '0);
                    n_res_ok = 1'b1;
                    n_state  = S_Q_OUT;
                end else begin
                    n_k     = r_k - 1'b1;
                    n_state = S_Q_K;
                end
            end
            S_Q_LIFT: begin
                row_raddr = lift_nx;
                if (r_rowx.depth > r_rowy.depth) begin
                    n_x     = lift_nx;
                    n_state = S_Q_LRD;
                end else if (r_x == r_y) begin
                    n_res    = r_x;
                    n_res_ok = 1'b1;
                    n_state  = S_Q_OUT;
                end else begin
                    n_k     = (r_rowx.depth != '0) ? prio_enc(r_rowx.depth - 1'b1) : '0;
                    n_state = S_Q_K;
                end
            end
            S_Q_LRD: begin
                n_rowx  = r_row_q;
                n_state = S_Q_LIFT;
            end
            S_Q_K: begin
                row_raddr = k_ax;
                if (k_ax != k_ay) begin
                    n_x     = k_ax;
                    n_y     = k_ay;
                    n_tail  = 1'b1;
                    n_state = S_Q_RX;
                end else if (r_k == '0) begin
                    n_res    = anc_sel(r_rowx, '0);
                    n_res_ok = 1'b1;
                    n_state  = S_Q_OUT;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            S_Q_OUT: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out_valid = 1'b1;
                    n_out_anc   = r_res;
                    n_out_ok    = r_res_ok;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_ecount    <= '0;
            r_built     <= 1'b0;
            r_sp        <= '0;
            r_root      <= NW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ecount    <= n_ecount;
            r_built     <= n_built;
            r_sp        <= n_sp;
            r_root      <= n_root;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_top_node <= n_top_node;
        r_top_iter <= n_top_iter;
        r_t        <= n_t;
        r_vnode    <= n_vnode;
        r_vpar     <= n_vpar;
        r_vrow     <= n_vrow;
        r_lvl      <= n_lvl;
        r_x        <= n_x;
        r_y        <= n_y;
        r_rowx     <= n_rowx;
        r_rowy     <= n_rowy;
        r_k        <= n_k;
        r_tail     <= n_tail;
        r_res      <= n_res;
        r_res_ok   <= n_res_ok;
        r_out_anc  <= n_out_anc;
        r_out_ok   <= n_out_ok;
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        r_head_q <= head_mem[head_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        r_edge_q <= edge_mem[edge_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            row_mem[row_waddr] <= row_wdata;
        end
        r_row_q <= row_mem[row_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        r_stk_q <= stk_mem[stk_raddr];
    end

endmodule

`default_nettype wire

FILE: src/lca_binary_lifting.sv
// Lowest common ancestor by binary lifting, top level.
// i_req carries words of three kinds: add edge (0), build tables (1) and
// query (2); code 3 is taken and dropped. Only a query gives a word on
// o_res: the ancestor and query_ok, which is 0 when no build has run.
// i_cfg_we / i_cfg_wdata write the root node used by the next build.
// Work per word: an add edge writes both list heads and edge slots, or
//   is dropped when the edge store is full; a query before a build is
//   answered with node zero; a query reads both node rows, lifts the
//   deeper node step by step, then scans the levels and moves both nodes
//   where their ancestors differ; a build clears the node table, then for
//   each node reached fills its table levels in order and walks its edge
//   slots, and each finished node returns up the stack.
// A two-word queue sits behind the request port, so words are taken while
// the engine works, and an output register holds a result while the
// receiver stalls; the engine waits only when a second result is ready.
// After reset the list heads are cleared while i_req.ready is low;
// configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module lca_binary_lifting (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    lcabl_in_if.sink                          i_req,
    lcabl_out_if.source                       o_res,
    input  wire logic                         i_cfg_we,
    input  wire logic [lcabl_pkg::NODE_FW-1:0] i_cfg_wdata
);
    import lcabl_pkg::*;

    t_back_stat stat;
    t_cmd       push_cmd, head_cmd;
    logic       push, q_full, q_valid, pop;

    lcabl_front u_front (
        .i_valid    (i_req.valid),
        .i_req_type (i_req.req_type),
        .i_node_a   (i_req.node_a),
        .i_node_b   (i_req.node_b),
        .o_ready    (i_req.ready),
        .i_q_full   (q_full),
        .i_stat     (stat),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    lcabl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    lcabl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .o_res_anc   (o_res.ancestor),
        .o_res_ok    (o_res.query_ok),
        .o_stat      (stat)
    );

endmodule

`default_nettype wire

FILE: src/lcabl_chk.sv
// port-level checks of the lca binary lifting block and their bind
`timescale 1ns / 1ps
`default_nettype none

`include "lca_binary_lifting_macros.svh"

module lcabl_chk (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_ready,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [lcabl_pkg::NODE_FW-1:0] i_anc,
    input wire logic                         i_ok
);

    // a result nobody took stays offered
    `LCABL_AST_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // a query without tables answers node zero
    `LCABL_AST_IMP(a_not_built_zero, i_clk, i_rst_n, i_out_valid && !i_ok, i_anc == '0)

    // list head clearing keeps the request port closed
    `LCABL_AST_RST(a_rst_closed, i_clk, i_rst_n, !i_in_ready)

    `LCABL_AST_RST(a_rst_no_result, i_clk, i_rst_n, !i_out_valid)

endmodule

bind lca_binary_lifting lcabl_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_anc       (o_res.ancestor),
    .i_ok        (o_res.query_ok)
);

`default_nettype wire

FILE: tb/sv/lca_binary_lifting_tb.sv
// self-checking testbench for the lca binary lifting block
`timescale 1ns / 1ps

module lca_binary_lifting_tb;
    import lcabl_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int WATCH_LIMIT = 400000;
    localparam int TBL_LEVELS = 10;
    localparam int TBL_NODES  = 1024;
    localparam int TBL_SLOTS  = 2048;

    typedef struct {
        logic [1:0] rq;
        logic [9:0] a;
        logic [9:0] b;
    } req_word_t;

    typedef struct {
        logic [9:0] anc;
        logic       ok;
    } lca_res_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [NODE_FW-1:0] i_cfg_wdata;

    lcabl_in_if  req_if ();
    lcabl_out_if res_if ();

    lca_binary_lifting uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if.sink),
        .o_res       (res_if.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // tree mirror
    logic [9:0]  e_tgt [TBL_SLOTS];
    logic [10:0] e_nxt [TBL_SLOTS];
    logic [10:0] head   [TBL_NODES];
    int          e_cnt;
    int          dep    [TBL_NODES];
    logic [9:0]  up     [TBL_NODES][TBL_LEVELS];
    bit          seen   [TBL_NODES];
    bit          built;
    logic [9:0]  root_sel;
    logic [9:0]  stk_node [TBL_NODES];
    logic [10:0] stk_iter [TBL_NODES];

    req_word_t pend_words [$];
    lca_res_t  want_lca   [$];

    int  mism_cnt;
    int  fail_cnt;
    int  idle_cnt;
    bit  quiet;
    bit  req_fire;
    int  src_gap;
    int  sink_gap;
    int  sink_long;
    int  long_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int bit_len(input int v);
        int n;
        n = 0;
        while (v != 0) begin
            n++;
            v = v >> 1;
        end
        return n;
    endfunction

    function automatic logic [9:0] up_at(input logic [9:0] nd, input int lv);
        if (lv >= TBL_LEVELS) begin
            return 10'd0;
        end
        return up[nd][lv];
    endfunction

    task automatic mark_node(input logic [9:0] nd, input logic [9:0] par);
        seen[nd] = 1'b1;
        dep[nd] = dep[par] + 1;
        up[nd][0] = par;
        for (int i = 1; i < TBL_LEVELS && (1 << i) <= dep[nd]; i++) begin
            up[nd][i] = up_at(up[nd][i-1], i - 1);
        end
    endtask

    task automatic build_tables();
        int sp;
        int it;
        logic [9:0] t;
        for (int n = 0; n < TBL_NODES; n++) begin
            dep[n] = 0;
            seen[n] = 1'b0;
            for (int l = 0; l < TBL_LEVELS; l++) begin
                up[n][l] = 10'd0;
            end
        end
        seen[0] = 1'b1;
        built = 1'b1;
        if (root_sel != 10'd0) begin
            mark_node(root_sel, 10'd0);
            stk_node[0] = root_sel;
            stk_iter[0] = head[root_sel];
            sp = 1;
            while (sp > 0) begin
                it = int'(stk_iter[sp-1]);
                if (it == 0) begin
                    sp--;
                end else begin
                    stk_iter[sp-1] = e_nxt[it];
                    t = e_tgt[it];
                    if (!seen[t] && sp < TBL_NODES) begin
                        mark_node(t, stk_node[sp-1]);
                        stk_node[sp] = t;
                        stk_iter[sp] = head[t];
                        sp++;
                    end
                end
            end
        end
    endtask

    function automatic logic [9:0] common_anc(input logic [9:0] x0, input logic [9:0] y0);
        logic [9:0] x, y, tmp, ax, ay;
        int k, guard;
        x = x0;
        y = y0;
        if (dep[x] < dep[y]) begin
            tmp = x; x = y; y = tmp;
        end
        guard = 0;
        while (guard <= TBL_NODES && dep[x] > dep[y]) begin
            x = up_at(x, bit_len(dep[x] - dep[y]) - 1);
            guard++;
        end
        if (x == y) begin
            return x;
        end
        k = (dep[x] > 0) ? bit_len(dep[x] - 1) : 0;
        forever begin
            ax = up_at(x, k);
            ay = up_at(y, k);
            if (ax != ay) begin
                x = ax;
                y = ay;
            end
            if (k == 0) break;
            k--;
        end
        return up_at(x, 0);
    endfunction

    task automatic apply_word(input req_word_t w);
        lca_res_t r;
        if (w.rq == REQ_ADD) begin
            if (e_cnt + 2 <= TBL_SLOTS - 1) begin
                e_cnt++;
                e_tgt[e_cnt] = w.b;
                e_nxt[e_cnt] = head[w.a];
                head[w.a] = 11'(e_cnt);
                e_cnt++;
                e_tgt[e_cnt] = w.a;
                e_nxt[e_cnt] = head[w.b];
                head[w.b] = 11'(e_cnt);
            end
        end else if (w.rq == REQ_BUILD) begin
            build_tables();
        end else if (w.rq == REQ_QUERY) begin
            if (!built) begin
                r.anc = 10'd0;
                r.ok = 1'b0;
            end else begin
                r.anc = common_anc(w.a, w.b);
                r.ok = 1'b1;
            end
            want_lca.push_back(r);
        end
    endtask

    // acceptance, prediction, result check and watchdog
    always @(posedge i_clk) begin
        req_word_t w;
        lca_res_t  r;
        req_fire <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                root_sel = i_cfg_wdata;
            end
            if (req_if.valid && req_if.ready) begin
                w.rq = req_if.req_type;
                w.a = req_if.node_a;
                w.b = req_if.node_b;
                apply_word(w);
            end
            if (res_if.valid && res_if.ready) begin
                if (want_lca.size() == 0) begin
                    fail_cnt++;
                    if (mism_cnt < 10) begin
                        $display("unexpected result word: anc=%0d ok=%0d",
                                 res_if.ancestor, res_if.query_ok);
                    end
                    mism_cnt++;
                end else begin
                    r = want_lca.pop_front();
                    if (res_if.ancestor !== r.anc || res_if.query_ok !== r.ok) begin
                        fail_cnt++;
                        if (mism_cnt < 10) begin
                            $display("mismatch: expected anc=%0d ok=%0d, got anc=%0d ok=%0d",
                                     r.anc, r.ok, res_if.ancestor, res_if.query_ok);
                        end
                        mism_cnt++;
                    end
                end
            end
            if ((pend_words.size() != 0 || want_lca.size() != 0 || req_if.valid)
                && !(req_if.valid && req_if.ready) && !(res_if.valid && res_if.ready)) begin
                idle_cnt++;
            end else begin
                idle_cnt = 0;
            end
            if (idle_cnt >= WATCH_LIMIT) begin
                $display("watchdog expired");
                $display("** lca_binary_lifting: FAILED **");
                $finish;
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        req_word_t w;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_fire) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                req_if.valid <= 1'b0;
            end else if (pend_words.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
                src_gap <= $urandom_range(0, 4);
                req_if.valid <= 1'b0;
            end else if (pend_words.size() != 0) begin
                w = pend_words.pop_front();
                req_if.req_type <= w.rq;
                req_if.node_a <= w.a;
                req_if.node_b <= w.b;
                req_if.valid <= 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // result receiver with stall bursts and one long hold-off
    always @(negedge i_clk) begin
        if (long_hold_req != 0) begin
            sink_long <= long_hold_req;
            long_hold_req <= 0;
            res_if.ready <= 1'b0;
        end else if (sink_long > 0) begin
            sink_long <= sink_long - 1;
            res_if.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            res_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            sink_gap <= $urandom_range(0, 4);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    task automatic put(input logic [1:0] rq, input logic [9:0] a, input logic [9:0] b);
        req_word_t w;
        w.rq = rq;
        w.a = a;
        w.b = b;
        pend_words.push_back(w);
    endtask

    task automatic drain();
        while (pend_words.size() != 0 || req_if.valid || want_lca.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // a query behind the build tells when the build is over
    task automatic settle_and_set_root(input logic [9:0] r);
        drain();
        put(REQ_QUERY, 10'd0, 10'd0);
        drain();
        repeat (100) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= r;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    logic [9:0] members [$];

    // random tree grown from rt; chain_pct biases toward long paths
    task automatic grow_tree(input logic [9:0] rt, input int n, input int chain_pct);
        logic [9:0] nd, par;
        members.delete();
        members.push_back(rt);
        for (int i = 0; i < n; i++) begin
            nd = 10'($urandom_range(1, 1023));
            if ($urandom_range(0, 99) < chain_pct) begin
                par = members[members.size()-1];
            end else begin
                par = members[$urandom_range(0, members.size()-1)];
            end
            if ($urandom_range(0, 1)) put(REQ_ADD, par, nd);
            else put(REQ_ADD, nd, par);
            members.push_back(nd);
        end
    endtask

    task automatic ask_many(input int n);
        logic [9:0] a, b;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: begin a = 10'($urandom); b = 10'($urandom); end
                1: begin a = members[$urandom_range(0, members.size()-1)]; b = a; end
                2: begin
                    a = members[$urandom_range(0, members.size()-1)];
                    b = 10'($urandom);
                end
                default: begin
                    a = members[$urandom_range(0, members.size()-1)];
                    b = members[$urandom_range(0, members.size()-1)];
                end
            endcase
            put(REQ_QUERY, a, b);
        end
    endtask

    task automatic noise(input int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: put(REQ_UNUSED, 10'($urandom), 10'($urandom));
                1: put(REQ_ADD, 10'($urandom), 10'($urandom));
                default: put(REQ_QUERY, 10'($urandom), 10'($urandom));
            endcase
        end
    endtask

    logic [9:0] phase_root;

    initial begin
        req_if.valid = 1'b0;
        req_if.req_type = '0;
        req_if.node_a = '0;
        req_if.node_b = '0;
        res_if.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        mism_cnt = 0;
        fail_cnt = 0;
        idle_cnt = 0;
        quiet = 1'b0;
        src_gap = 0;
        sink_gap = 0;
        sink_long = 0;
        long_hold_req = 0;
        e_cnt = 0;
        built = 1'b0;
        root_sel = 10'd1;
        for (int n = 0; n < TBL_NODES; n++) begin
            head[n] = '0;
            dep[n] = 0;
            seen[n] = 1'b0;
            for (int l = 0; l < TBL_LEVELS; l++) up[n][l] = 10'd0;
        end
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: query before any build, unused code, edges to node 0 and 1023
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= 10'd1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        put(REQ_QUERY, 10'd1, 10'd2);
        put(REQ_UNUSED, 10'h3ff, 10'h3ff);
        put(REQ_ADD, 10'd1, 10'd2);
        put(REQ_ADD, 10'd1, 10'd3);
        put(REQ_ADD, 10'd2, 10'd4);
        put(REQ_ADD, 10'd2, 10'd0);
        put(REQ_ADD, 10'd4, 10'd1023);
        put(REQ_ADD, 10'd3, 10'd1);
        put(REQ_ADD, 10'd4, 10'd3);
        put(REQ_ADD, 10'd5, 10'd5);
        put(REQ_BUILD, 10'h3ff, 10'h3ff);
        put(REQ_QUERY, 10'd4, 10'd3);
        put(REQ_QUERY, 10'd1023, 10'd2);
        put(REQ_QUERY, 10'd1023, 10'd1023);
        put(REQ_QUERY, 10'd0, 10'd0);
        put(REQ_QUERY, 10'd0, 10'd4);
        put(REQ_QUERY, 10'd5, 10'd5);
        put(REQ_QUERY, 10'd6, 10'd1);
        put(REQ_QUERY, 10'd1, 10'd1023);
        // deep path past 256 levels from node 1
        put(REQ_ADD, 10'd1, 10'd600);
        for (int i = 600; i < 899; i++) put(REQ_ADD, i[9:0], 10'(i + 1));
        put(REQ_BUILD, 10'd0, 10'd0);
        put(REQ_QUERY, 10'd899, 10'd1023);
        put(REQ_QUERY, 10'd899, 10'd700);
        put(REQ_QUERY, 10'd856, 10'd899);
        put(REQ_QUERY, 10'd600, 10'd899);
        for (int i = 0; i < 10; i++) begin
            put(REQ_QUERY, 10'($urandom_range(600, 899)), 10'($urandom_range(600, 899)));
        end

        // root zero builds nothing
        settle_and_set_root(10'd0);
        put(REQ_BUILD, 10'd0, 10'd0);
        put(REQ_QUERY, 10'd1, 10'd2);
        put(REQ_QUERY, 10'd3, 10'd3);
        put(REQ_QUERY, 10'd899, 10'd0);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: phase_root = 10'd1023;
                1: phase_root = 10'd1;
                default: phase_root = 10'($urandom_range(1, 1023));
            endcase
            settle_and_set_root(phase_root);
            grow_tree(phase_root, 40, (ph % 2 == 0) ? 70 : 20);
            noise(8);
            put(REQ_BUILD, 10'($urandom), 10'($urandom));
            if (ph == 2) begin
                // long receiver hold-off while queries keep coming
                drain();
                long_hold_req = 400;
            end
            if (ph == 5) quiet = 1'b1;
            ask_many(20);
            noise(4);
            put(REQ_ADD, phase_root, 10'($urandom));
            ask_many(6);
        end
        // overflow the edge store, then rebuild
        settle_and_set_root(10'd1);
        for (int i = 0; i < 480; i++) put(REQ_ADD, 10'($urandom), 10'($urandom));
        put(REQ_BUILD, 10'd0, 10'd0);
        members.delete();
        members.push_back(10'd1);
        members.push_back(10'd899);
        members.push_back(10'd700);
        members.push_back(10'd3);
        ask_many(20);

        drain();
        repeat (2000) @(posedge i_clk);
        if (fail_cnt == 0 && want_lca.size() == 0) begin
            $display("** lca_binary_lifting: PASSED **");
        end else begin
            $display("** lca_binary_lifting: FAILED **");
        end
        $finish;
    end

endmodule
